// ===== rtl/core/bzfc_pkg.sv =====
// Package: types, constants and helpers shared by the band z-score fault classifier.
`timescale 1ns / 1ps
package bzfc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_BANDS = 4;
  localparam int BAND_W    = 2;
  localparam int IN_W      = 32;
  localparam int NUM_W     = IN_W + FRAC_BITS;
  localparam int TH_W      = 31;
  localparam int CONF_W    = 31;
  localparam int LABEL_W   = 3;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int LATENCY   = NUM_W + 3;

  localparam logic [IN_W-1:0] DEV_ONE = IN_W'(64'd1 << FRAC_BITS);
  localparam logic [IN_W-1:0] DEV_MIN = IN_W'((64'd1 << FRAC_BITS) / 10000);

  localparam logic [TH_W-1:0] TH_RESET = TH_W'(131072);

  // register index, taken from paddr above the byte offset
  localparam logic REG_Z_THRESHOLD = 1'b0;

  typedef enum logic [LABEL_W-1:0] {
    LABEL_NORMAL     = 3'd0,
    LABEL_UNBALANCE  = 3'd1,
    LABEL_MISALIGN   = 3'd2,
    LABEL_OUTER_RACE = 3'd3,
    LABEL_INNER_RACE = 3'd4
  } bzfc_label_e;

  typedef struct packed {
    logic [IN_W-1:0] energy_band0;
    logic [IN_W-1:0] energy_band1;
    logic [IN_W-1:0] energy_band2;
    logic [IN_W-1:0] energy_band3;
    logic [IN_W-1:0] mean_band0;
    logic [IN_W-1:0] mean_band1;
    logic [IN_W-1:0] mean_band2;
    logic [IN_W-1:0] mean_band3;
    logic [IN_W-1:0] dev_band0;
    logic [IN_W-1:0] dev_band1;
    logic [IN_W-1:0] dev_band2;
    logic [IN_W-1:0] dev_band3;
  } bzfc_req_t;

  typedef struct packed {
    logic [LABEL_W-1:0] fault_label;
    logic [CONF_W-1:0]  confidence;
  } bzfc_res_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [NUM_W-1:0] quot;
  } bzfc_lane_t;

  function automatic bzfc_label_e band_label(input logic [BAND_W-1:0] band);
    bzfc_label_e lbl;
    case (band)
      2'd0:    lbl = LABEL_UNBALANCE;
      2'd1:    lbl = LABEL_MISALIGN;
      2'd2:    lbl = LABEL_OUTER_RACE;
      2'd3:    lbl = LABEL_INNER_RACE;
      default: lbl = LABEL_NORMAL;
    endcase
    return lbl;
  endfunction

endpackage

// ===== rtl/core/bzfc_lane.sv =====
// One band lane: deviation clamp, magnitude and a bit-per-stage pipelined divider.
`timescale 1ns / 1ps
module bzfc_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [bzfc_pkg::IN_W-1:0]    energy_i,
  input  logic [bzfc_pkg::IN_W-1:0]    mean_i,
  input  logic [bzfc_pkg::IN_W-1:0]    dev_i,
  output bzfc_pkg::bzfc_lane_t         res_o
);
  import bzfc_pkg::*;

  logic              v_q   [0:NUM_W];
  logic              neg_q [0:NUM_W];
  logic [IN_W-1:0]   d_q   [0:NUM_W];
  logic [IN_W-1:0]   a_q   [0:NUM_W];
  logic [NUM_W-1:0]  n_q   [0:NUM_W];

  logic              neg_d;
  logic [IN_W-1:0]   mag_d;
  logic [IN_W-1:0]   div_d;

  always_comb begin
    neg_d = mean_i > energy_i;
    mag_d = neg_d ? (mean_i - energy_i) : (energy_i - mean_i);
    div_d = (dev_i > DEV_MIN) ? dev_i : DEV_ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q[0] <= neg_d;
    d_q[0]   <= div_d;
    a_q[0]   <= '0;
    n_q[0]   <= {mag_d, {FRAC_BITS{1'b0}}};
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [IN_W:0]    sh;
    logic [IN_W:0]    diff;
    logic             ge;
    logic [IN_W-1:0]  a_d;
    logic [NUM_W-1:0] n_d;

    always_comb begin
      sh   = {a_q[k], n_q[k][NUM_W-1]};
      diff = sh - {1'b0, d_q[k]};
      ge   = sh >= {1'b0, d_q[k]};
      a_d  = ge ? diff[IN_W-1:0] : sh[IN_W-1:0];
      n_d  = {n_q[k][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      neg_q[k+1] <= neg_q[k];
      d_q[k+1]   <= d_q[k];
      a_q[k+1]   <= a_d;
      n_q[k+1]   <= n_d;
    end
  end

  assign res_o.valid = v_q[NUM_W];
  assign res_o.neg   = neg_q[NUM_W];
  assign res_o.quot  = n_q[NUM_W];

endmodule

// ===== rtl/core/bzfc_merge.sv =====
// Merge: argmax over the lane scores, threshold test, label and saturated confidence.
`timescale 1ns / 1ps
module bzfc_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bzfc_pkg::bzfc_lane_t       lane_i [bzfc_pkg::NUM_BANDS],
  input  logic [bzfc_pkg::TH_W-1:0]  thresh_i,
  output logic                       done_o,
  output bzfc_pkg::bzfc_res_t        res_o
);
  import bzfc_pkg::*;

  typedef logic signed [NUM_W:0] score_t;

  localparam score_t CONF_MAX = score_t'({CONF_W{1'b1}});

  function automatic score_t to_score(input bzfc_lane_t l);
    score_t s;
    s = $signed({1'b0, l.quot});
    return l.neg ? -s : s;
  endfunction

  score_t s0, s1, s2, s3;
  logic   pick1, pick3, pick_hi;

  logic              va_q, vb_q, done_q;
  score_t            w01_q, w23_q, best_q;
  logic [BAND_W-1:0] i01_q, i23_q, ibest_q;
  bzfc_res_t         res_d, res_q;
  score_t            th_s;

  always_comb begin
    s0    = to_score(lane_i[0]);
    s1    = to_score(lane_i[1]);
    s2    = to_score(lane_i[2]);
    s3    = to_score(lane_i[3]);
    pick1 = s1 > s0;
    pick3 = s3 > s2;
    pick_hi = w23_q > w01_q;
  end

  always_comb begin
    th_s = $signed({{(NUM_W + 1 - TH_W){1'b0}}, thresh_i});
    if (best_q < th_s) begin
      res_d.fault_label = LABEL_NORMAL;
      res_d.confidence  = '0;
    end else begin
      res_d.fault_label = band_label(ibest_q);
      res_d.confidence  = (best_q > CONF_MAX) ? CONF_MAX[CONF_W-1:0] : best_q[CONF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      va_q   <= lane_i[0].valid;
      vb_q   <= va_q;
      done_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w01_q   <= pick1 ? s1 : s0;
    i01_q   <= pick1 ? BAND_W'(1) : BAND_W'(0);
    w23_q   <= pick3 ? s3 : s2;
    i23_q   <= pick3 ? BAND_W'(3) : BAND_W'(2);
    best_q  <= pick_hi ? w23_q : w01_q;
    ibest_q <= pick_hi ? i23_q : i01_q;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/band_zscore_fault_classifier_unit.sv =====
// Top level: band z-score fault classifier with APB threshold register.
//
// Usage: drive req_i with a frame of four band energies, means and deviations
// and pulse start_i; the request is taken on any edge with start_i high and
// busy_o low. busy_o stays low, so a new request may be issued every cycle.
// Each band runs in its own lane; a lane divides with one quotient bit per
// pipeline stage, 32 + FRAC_BITS stages, then a three-stage merge picks the
// largest score and applies the threshold.
// Result: done_o is high for one cycle per request, with res_o valid in that cycle
// only; band energies, means and deviations are Q16.16.
// Throughput: one request per cycle, set by the pipelined lane dividers.
// The receiver cannot stall; results must be taken when done_o is high.
// APB: z_threshold at byte address 0, always ready; the user must write it only while idle (not enforced by the block).
// Reset: clears all pipeline valids and loads z_threshold with 2.0.
`timescale 1ns / 1ps
module band_zscore_fault_classifier_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  bzfc_pkg::bzfc_req_t           req_i,
  output logic                          done_o,
  output bzfc_pkg::bzfc_res_t           res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bzfc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bzfc_pkg::DATA_W-1:0]   pwdata,
  output logic [bzfc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import bzfc_pkg::*;

  logic [TH_W-1:0] thresh_q, thresh_d;
  logic            cfg_wr;
  logic            accept;

  logic [IN_W-1:0] energy [NUM_BANDS];
  logic [IN_W-1:0] mean   [NUM_BANDS];
  logic [IN_W-1:0] dev    [NUM_BANDS];
  bzfc_lane_t      lane_res [NUM_BANDS];
  logic [NUM_BANDS-1:0] lane_vld;

  assign busy_o = 1'b0;
  assign pready = 1'b1;
  assign accept = start_i && !busy_o;

  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_Z_THRESHOLD);

  always_comb begin
    thresh_d = thresh_q;
    if (cfg_wr) begin
      thresh_d = pwdata[TH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= TH_RESET;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  assign prdata = (paddr[2] == REG_Z_THRESHOLD) ?
                  {{(DATA_W - TH_W){1'b0}}, thresh_q} : '0;

  always_comb begin
    energy[0] = req_i.energy_band0;
    energy[1] = req_i.energy_band1;
    energy[2] = req_i.energy_band2;
    energy[3] = req_i.energy_band3;
    mean[0]   = req_i.mean_band0;
    mean[1]   = req_i.mean_band1;
    mean[2]   = req_i.mean_band2;
    mean[3]   = req_i.mean_band3;
    dev[0]    = req_i.dev_band0;
    dev[1]    = req_i.dev_band1;
    dev[2]    = req_i.dev_band2;
    dev[3]    = req_i.dev_band3;
  end

  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_lane
    bzfc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (accept),
      .energy_i (energy[b]),
      .mean_i   (mean[b]),
      .dev_i    (dev[b]),
      .res_o    (lane_res[b])
    );
    assign lane_vld[b] = lane_res[b].valid;
  end

  bzfc_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .lane_i   (lane_res),
    .thresh_i (thresh_q),
    .done_o   (done_o),
    .res_o    (res_o)
  );

`ifndef ASSERT_OFF
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(lane_vld) == 0) || ($countones(lane_vld) == NUM_BANDS))
    else $error("lane valids out of step");

  a_label_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.fault_label <= LABEL_INNER_RACE))
    else $error("fault label out of range");

  a_normal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.fault_label == LABEL_NORMAL)) |-> (res_o.confidence == '0))
    else $error("normal result with nonzero confidence");

  a_done_follows_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_vld[0] |=> ##2 done_o)
    else $error("merge dropped a request");
`endif

endmodule
